### hdl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, types and helper functions for the integer to text block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 32;

  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = $clog2(MAX_DIGITS + 1);
  localparam int INDEX_W = $clog2(MAX_DIGITS);

  // divider retires this many quotient bits per cycle
  localparam int CHUNK      = 8;
  localparam int NUM_CHUNKS = (VALUE_WIDTH + CHUNK - 1) / CHUNK;
  localparam int PAD_W      = NUM_CHUNKS * CHUNK;
  localparam int DCNT_W     = $clog2(NUM_CHUNKS + 1);

  localparam logic [DIGIT_W-1:0] BASE_MIN   = DIGIT_W'(2);
  localparam logic [DIGIT_W-1:0] BASE_MAX   = DIGIT_W'(36);
  localparam logic [DIGIT_W-1:0] BASE_RESET = DIGIT_W'(10);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = DIGIT_W'(9);

  localparam logic [CHAR_W-1:0] LETTER_OFFSET = CHAR_W'(87);
  localparam logic [CHAR_W-1:0] ZERO_CHAR     = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] MINUS_CHAR    = CHAR_W'(45);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_SIGN,
    S_DIGITS
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [DIGIT_W-1:0] eff_base(input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W-1:0] r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_MAX) begin
      c = CHAR_W'(d) + LETTER_OFFSET;
    end else begin
      c = CHAR_W'(d) + ZERO_CHAR;
    end
    return c;
  endfunction

endpackage

### hdl/itoa_div.sv
// ----------------------------------------------------------------------------
// itoa_div
// Shared restoring divider: magnitude by a small base, several bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itoa_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [itoa_pkg::VALUE_WIDTH-1:0]    dividend,
  input  logic [itoa_pkg::DIGIT_W-1:0]        base,
  output logic [itoa_pkg::VALUE_WIDTH-1:0]    quotient,
  output logic [itoa_pkg::DIGIT_W-1:0]        remainder,
  output itoa_pkg::div_status_t               status
);

  logic [itoa_pkg::PAD_W-1:0]  shreg;
  logic [itoa_pkg::PAD_W-1:0]  shreg_next;
  logic [itoa_pkg::DIGIT_W-1:0] rem;
  logic [itoa_pkg::DIGIT_W-1:0] rem_next;
  logic [itoa_pkg::DCNT_W-1:0] cnt;
  logic                        busy;
  logic                        done;

  logic [itoa_pkg::CHUNK-1:0]          top_bits;
  logic [itoa_pkg::CHUNK-1:0]          qbits;
  logic [itoa_pkg::PAD_W+itoa_pkg::CHUNK-1:0] joined;
  logic [itoa_pkg::DIGIT_W:0]          r;

  // one chunk of restoring division steps
  always_comb begin
    top_bits = shreg[itoa_pkg::PAD_W-1 -: itoa_pkg::CHUNK];
    r        = {1'b0, rem};
    qbits    = '0;
    for (int i = itoa_pkg::CHUNK - 1; i >= 0; i--) begin
      r = {r[itoa_pkg::DIGIT_W-1:0], top_bits[i]};
      if (r >= {1'b0, base}) begin
        r        = r - {1'b0, base};
        qbits[i] = 1'b1;
      end
    end
    joined     = {shreg, qbits};
    shreg_next = joined[itoa_pkg::PAD_W-1:0];
    rem_next   = r[itoa_pkg::DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= itoa_pkg::DCNT_W'(itoa_pkg::NUM_CHUNKS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == itoa_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= itoa_pkg::PAD_W'(dividend);
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg_next;
      rem   <= rem_next;
    end
  end

  assign quotient    = shreg[itoa_pkg::VALUE_WIDTH-1:0];
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

endmodule

### hdl/signed_int_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// signed_int_to_ascii_digits
// Converts a signed integer to ASCII text in a configurable base.
// ----------------------------------------------------------------------------
// Input channel: value with in_valid / in_stall; an item is taken when
// in_valid is high and in_stall low. in_stall is high while a conversion runs.
// Output channel: one character per item with out_valid / out_stall; a '-'
// comes first for negative values, then digits most significant first, and
// last_char marks the final character. No terminator is sent.
// Config channel: digit_base with cfg_valid / cfg_ready, written while idle
// and no input item is offered.
// Values below 2 act as 2 and above 36 act as 36. Reset base is 10.
// Each digit is computed in turn in the shared divider, which retires 8
// quotient bits per cycle; then the characters are emitted, one character
// per cycle while the output is not stalled.
// Reset (synchronous, rst high) returns to idle and drops out_valid.
// A stalled output holds its character; emission pauses until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_int_to_ascii_digits (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [itoa_pkg::VALUE_WIDTH-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [itoa_pkg::CHAR_W-1:0]          character,
  output logic                                 last_char,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [itoa_pkg::DIGIT_W-1:0]         digit_base
);

  itoa_pkg::state_t state;
  itoa_pkg::state_t state_next;

  logic [itoa_pkg::DIGIT_W-1:0]     base_reg;
  logic [itoa_pkg::VALUE_WIDTH-1:0] mag;
  logic [itoa_pkg::VALUE_WIDTH-1:0] mag_next;
  logic                             neg;
  logic                             neg_next;
  logic [itoa_pkg::COUNT_W-1:0]     cnt;
  logic [itoa_pkg::COUNT_W-1:0]     cnt_next;
  logic [itoa_pkg::COUNT_W-1:0]     rd_cnt;
  logic [itoa_pkg::COUNT_W-1:0]     rd_cnt_next;
  logic [itoa_pkg::DIGIT_W-1:0]     store [itoa_pkg::MAX_DIGITS];

  logic                             out_valid_next;
  logic [itoa_pkg::CHAR_W-1:0]      character_next;
  logic                             last_char_next;
  logic                             out_free;

  logic                             div_start;
  logic [itoa_pkg::VALUE_WIDTH-1:0] div_q;
  logic [itoa_pkg::DIGIT_W-1:0]     div_r;
  itoa_pkg::div_status_t            div_st;

  logic                             store_we;
  logic [itoa_pkg::COUNT_W-1:0]     cnt_inc;
  logic [itoa_pkg::COUNT_W-1:0]     rd_prev;
  logic [itoa_pkg::VALUE_WIDTH-1:0] value_u;

  itoa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .base      (itoa_pkg::eff_base(base_reg)),
    .quotient  (div_q),
    .remainder (div_r),
    .status    (div_st)
  );

  assign cfg_ready = (state == itoa_pkg::S_IDLE) && !in_valid;
  assign in_stall  = (state != itoa_pkg::S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign cnt_inc   = cnt + 1'b1;
  assign rd_prev   = rd_cnt - 1'b1;
  assign value_u   = $unsigned(value);

  always_comb begin
    state_next     = state;
    mag_next       = mag;
    neg_next       = neg;
    cnt_next       = cnt;
    rd_cnt_next    = rd_cnt;
    out_valid_next = out_valid && out_stall;
    character_next = character;
    last_char_next = last_char;
    div_start      = 1'b0;
    store_we       = 1'b0;
    case (state)
      itoa_pkg::S_IDLE: begin
        if (in_valid) begin
          neg_next   = value_u[itoa_pkg::VALUE_WIDTH-1];
          mag_next   = value_u[itoa_pkg::VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;
          cnt_next   = '0;
          state_next = itoa_pkg::S_START;
        end
      end
      itoa_pkg::S_START: begin
        div_start  = 1'b1;
        state_next = itoa_pkg::S_WAIT;
      end
      itoa_pkg::S_WAIT: begin
        if (div_st.done) begin
          store_we = 1'b1;
          mag_next = div_q;
          cnt_next = cnt_inc;
          if (div_q != '0 && cnt_inc < itoa_pkg::COUNT_W'(itoa_pkg::MAX_DIGITS)) begin
            state_next = itoa_pkg::S_START;
          end else begin
            rd_cnt_next = cnt_inc;
            state_next  = neg ? itoa_pkg::S_SIGN : itoa_pkg::S_DIGITS;
          end
        end
      end
      itoa_pkg::S_SIGN: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          character_next = itoa_pkg::MINUS_CHAR;
          last_char_next = 1'b0;
          state_next     = itoa_pkg::S_DIGITS;
        end
      end
      itoa_pkg::S_DIGITS: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          character_next = itoa_pkg::digit_char(store[rd_prev[itoa_pkg::INDEX_W-1:0]]);
          last_char_next = (rd_cnt == itoa_pkg::COUNT_W'(1));
          rd_cnt_next    = rd_prev;
          if (rd_cnt == itoa_pkg::COUNT_W'(1)) begin
            state_next = itoa_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = itoa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= itoa_pkg::S_IDLE;
      base_reg  <= itoa_pkg::BASE_RESET;
      out_valid <= 1'b0;
      cnt       <= '0;
      rd_cnt    <= '0;
      neg       <= 1'b0;
      mag       <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
      rd_cnt    <= rd_cnt_next;
      neg       <= neg_next;
      mag       <= mag_next;
      if (cfg_valid && cfg_ready) begin
        base_reg <= digit_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    character <= character_next;
    last_char <= last_char_next;
    if (store_we) begin
      store[cnt[itoa_pkg::INDEX_W-1:0]] <= div_r;
    end
  end

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == itoa_pkg::S_WAIT)
    else $error("divider finished outside wait state");

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= itoa_pkg::COUNT_W'(itoa_pkg::MAX_DIGITS) &&
    rd_cnt <= itoa_pkg::COUNT_W'(itoa_pkg::MAX_DIGITS))
    else $error("digit count out of range");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == itoa_pkg::S_DIGITS |-> rd_cnt != '0)
    else $error("emitting with no digits left");
`endif

endmodule

### tb/signed_int_to_ascii_digits_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_ascii_digits_tb
// Self-checking bench for the signed integer to ASCII text converter. Values
// go in through a random-gap sender. The characters come back through a
// receiver that stalls at random. A scoreboard works out the expected text
// for each accepted value in the current base, and checks every character in
// order. The run covers saturated, extreme and typical base settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_int_to_ascii_digits_tb;
  import itoa_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int PHASE_ITEMS = 33;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES = 64;

  class char_scoreboard;
    typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              last;
    } text_char_t;

    text_char_t text_q[$];
    int errors;

    function void note_value(input logic signed [VALUE_WIDTH-1:0] v,
                             input logic [DIGIT_W-1:0] base_reg);
      logic [VALUE_WIDTH-1:0] mag;
      logic [VALUE_WIDTH-1:0] radix;
      logic [DIGIT_W-1:0] digits [MAX_DIGITS];
      text_char_t tc;
      int n;
      if (base_reg < BASE_MIN) begin
        radix = VALUE_WIDTH'(BASE_MIN);
      end else if (base_reg > BASE_MAX) begin
        radix = VALUE_WIDTH'(BASE_MAX);
      end else begin
        radix = VALUE_WIDTH'(base_reg);
      end
      mag = v;
      if (v[VALUE_WIDTH-1]) begin
        mag = ~mag + 1'b1;
      end
      n = 0;
      do begin
        digits[n] = DIGIT_W'(mag % radix);
        mag = mag / radix;
        n++;
      end while (mag != 0 && n < MAX_DIGITS);
      if (v[VALUE_WIDTH-1]) begin
        tc.ch = MINUS_CHAR;
        tc.last = 1'b0;
        text_q.push_back(tc);
      end
      for (int k = n - 1; k >= 0; k--) begin
        if (digits[k] > DIGIT_MAX) begin
          tc.ch = CHAR_W'(digits[k]) + LETTER_OFFSET;
        end else begin
          tc.ch = CHAR_W'(digits[k]) + ZERO_CHAR;
        end
        tc.last = (k == 0);
        text_q.push_back(tc);
      end
    endfunction

    function void check_char(input logic [CHAR_W-1:0] ch, input logic last);
      text_char_t tc;
      if (text_q.size() == 0) begin
        $error("unexpected item: character %0d last_char %0b", ch, last);
        errors++;
      end else begin
        tc = text_q.pop_front();
        if (ch !== tc.ch) begin
          $error("character: expected %0d, got %0d", tc.ch, ch);
          errors++;
        end
        if (last !== tc.last) begin
          $error("last_char: expected %0b, got %0b", tc.last, last);
          errors++;
        end
      end
    endfunction

    function int pending();
      return text_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [VALUE_WIDTH-1:0] value;
  logic out_valid;
  logic out_stall;
  logic [CHAR_W-1:0] character;
  logic last_char;
  logic cfg_valid;
  logic cfg_ready;
  logic [DIGIT_W-1:0] digit_base;

  char_scoreboard book;
  logic [DIGIT_W-1:0] cur_base;
  logic calm;
  int cycles;

  signed_int_to_ascii_digits uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .character(character),
    .last_char(last_char),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .digit_base(digit_base)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] pick_value(input logic [DIGIT_W-1:0] b);
    logic [VALUE_WIDTH-1:0] r;
    logic [63:0] p;
    int k;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: r = $urandom_range(0, 40);
      1: r = -$urandom_range(0, 40);
      2: begin
        case ($urandom_range(0, 4))
          0: r = 32'h8000_0000;
          1: r = 32'h7fff_ffff;
          2: r = 32'hffff_ffff;
          3: r = 32'h8000_0001;
          default: r = 32'h0;
        endcase
      end
      3: begin
        p = 1;
        k = $urandom_range(1, 31);
        while (k > 0 && p * ((b < BASE_MIN) ? BASE_MIN : (b > BASE_MAX) ? BASE_MAX : b)
               < 64'h8000_0000) begin
          p = p * ((b < BASE_MIN) ? BASE_MIN : (b > BASE_MAX) ? BASE_MAX : b);
          k--;
        end
        r = p[VALUE_WIDTH-1:0] - $urandom_range(0, 1);
        if ($urandom_range(0, 1)) begin
          r = -r;
        end
      end
      4: r = $urandom_range(0, 4000) - 2000;
      default: r = $urandom;
    endcase
    return r;
  endfunction

  task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    value = v;
    do @(posedge clk); while (in_stall !== 1'b0);
    book.note_value(v, cur_base);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_base(input logic [DIGIT_W-1:0] b);
    cfg_valid = 1'b1;
    digit_base = b;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cur_base = b;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver side
  initial begin
    int gap;
    out_stall = 1'b1;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      book.check_char(character, last_char);
      @(negedge clk);
    end
  end

  initial begin
    logic [DIGIT_W-1:0] bases [$];
    logic signed [VALUE_WIDTH-1:0] directed [$];
    book = new();
    cycles = 0;
    calm = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    cfg_valid = 1'b0;
    digit_base = BASE_RESET;
    cur_base = BASE_RESET;
    bases = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd16, 6'd37, 6'd1, 6'd8, 6'd10, 6'd7, 6'd35,
              6'd3, 6'd11};
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, -32'sd100,
                 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0001, 32'sd123456789,
                 -32'sd987654321, 32'sd1000000000};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset base first
    foreach (directed[i]) send_value(directed[i]);

    bases.push_back(DIGIT_W'($urandom_range(0, 63)));
    foreach (bases[p]) begin
      wait_drained();
      write_base(bases[p]);
      calm = ($urandom_range(0, 3) == 0);
      send_value(32'sh8000_0000);
      send_value(-32'sd35);
      for (int i = 0; i < PHASE_ITEMS - 2; i++) begin
        send_value(pick_value(cur_base));
      end
    end

    in_valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/itoa_pkg.sv
hdl/itoa_div.sv
hdl/signed_int_to_ascii_digits.sv
tb/signed_int_to_ascii_digits_tb.sv
